>>> design/tga_pkg.sv
// TGA stream decoder package: beat types, parser phase enum, header offsets
// and pixel depth codes. Used by every module of the decoder; no dependencies.
`timescale 1ns / 1ps

package tga_pkg;

  localparam logic [14:0] MAX_SIDE = 15'd32767;

  // header byte offsets
  localparam logic [4:0] HDR_ID_LEN = 5'd0;
  localparam logic [4:0] HDR_TYPE   = 5'd2;
  localparam logic [4:0] HDR_W_LO   = 5'd12;
  localparam logic [4:0] HDR_W_HI   = 5'd13;
  localparam logic [4:0] HDR_H_LO   = 5'd14;
  localparam logic [4:0] HDR_H_HI   = 5'd15;
  localparam logic [4:0] HDR_DEPTH  = 5'd16;
  localparam logic [4:0] HDR_LAST   = 5'd17;

  localparam logic [7:0] TYPE_RLE = 8'd10;

  localparam logic [5:0] PIX_16 = 6'd16;
  localparam logic [5:0] PIX_24 = 6'd24;
  localparam logic [5:0] PIX_32 = 6'd32;

  localparam logic [2:0] CH_RGB  = 3'd3;
  localparam logic [2:0] CH_RGBA = 3'd4;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_HEADER,
    PH_PIXELS,
    PH_DONE
  } tga_phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       file_start;
  } tga_in_t;

  typedef struct packed {
    logic [7:0]  chan0;
    logic [7:0]  chan1;
    logic [7:0]  chan2;
    logic [7:0]  chan3;
    logic [2:0]  channel_count;
    logic [7:0]  repeat_count;
    logic        last_pixel;
    logic        error_code;
    logic [14:0] image_width;
    logic [14:0] image_height;
  } tga_out_t;

  // input register to parser
  typedef struct packed {
    logic    valid;
    tga_in_t beat;
  } tga_stage_t;

  // clamp a 16-bit header dimension
  function automatic logic [14:0] sat_side(input logic [15:0] v);
    logic [14:0] r;
    r = (v > {1'b0, MAX_SIDE}) ? MAX_SIDE : v[14:0];
    return r;
  endfunction

endpackage

>>> design/tga_in_reg.sv
// TGA decoder input register: holds one accepted beat until the parser takes it.
// Depends on tga_pkg.
`timescale 1ns / 1ps

module tga_in_reg (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  tga_pkg::tga_in_t    in_data,
  input  logic                take,
  output tga_pkg::tga_stage_t stage
);
  import tga_pkg::*;

  logic    vld_r;
  tga_in_t beat_r;

  assign in_ready = !vld_r || take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_ready) begin
      vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      beat_r <= in_data;
    end
  end

  assign stage.valid = vld_r;
  assign stage.beat  = beat_r;

endmodule

>>> design/tga_parser.sv
// TGA decoder parser: header, id skip, RLE packets and pixel assembly, one beat
// per advance. Depends on tga_pkg.
`timescale 1ns / 1ps

module tga_parser (
  input  logic                clk,
  input  logic                rst_n,
  input  tga_pkg::tga_stage_t stage,
  input  logic                advance,
  output logic                res_valid,
  output tga_pkg::tga_out_t   res
);
  import tga_pkg::*;

  tga_phase_t  phase_r, phase_nxt, ph_eff;
  logic [4:0]  hdr_pos_r, hdr_pos_nxt, pos_eff;
  logic [7:0]  id_skip_r, id_skip_nxt;
  logic        rle_r, rle_nxt;
  logic [14:0] width_r, width_nxt;
  logic [14:0] height_r, height_nxt;
  logic [5:0]  depth_r, depth_nxt, depth_eff;
  logic [29:0] total_r;
  logic [29:0] remaining_r, remaining_nxt;
  logic [7:0]  pkt_rem_r, pkt_rem_nxt;
  logic        pkt_rep_r, pkt_rep_nxt;
  logic [1:0]  byte_idx_r, byte_idx_nxt;
  logic [23:0] partial_r, partial_nxt;

  logic        fs;
  logic [7:0]  b;
  logic        pix_last;
  logic [7:0]  pk;
  logic [7:0]  n;
  logic [15:0] v16;

  assign fs        = stage.beat.file_start;
  assign b         = stage.beat.data_byte;
  assign ph_eff    = fs ? PH_HEADER : phase_r;
  assign pos_eff   = fs ? HDR_ID_LEN : hdr_pos_r;
  assign depth_eff = fs ? '0 : depth_r;

  // next phase
  always_comb begin
    phase_nxt = phase_r;
    if (advance) begin
      phase_nxt = ph_eff;
      case (ph_eff)
        PH_HEADER: begin
          if (pos_eff == HDR_LAST) begin
            if (depth_eff == '0 || total_r == '0) begin
              phase_nxt = PH_DONE;
            end else begin
              phase_nxt = PH_PIXELS;
            end
          end
        end
        PH_PIXELS: begin
          if (pix_last) begin
            phase_nxt = PH_DONE;
          end
        end
        default: ;
      endcase
    end
  end

  // datapath and result
  always_comb begin
    hdr_pos_nxt   = hdr_pos_r;
    id_skip_nxt   = id_skip_r;
    rle_nxt       = rle_r;
    width_nxt     = width_r;
    height_nxt    = height_r;
    depth_nxt     = depth_r;
    remaining_nxt = remaining_r;
    pkt_rem_nxt   = pkt_rem_r;
    pkt_rep_nxt   = pkt_rep_r;
    byte_idx_nxt  = byte_idx_r;
    partial_nxt   = partial_r;
    res_valid     = 1'b0;
    res           = '0;
    pix_last      = 1'b0;
    pk            = {1'b0, b[6:0]} + 8'd1;
    n             = 8'd1;
    v16           = {b, partial_r[7:0]};

    if (advance) begin
      if (fs) begin
        hdr_pos_nxt   = '0;
        id_skip_nxt   = '0;
        rle_nxt       = 1'b0;
        width_nxt     = '0;
        height_nxt    = '0;
        depth_nxt     = '0;
        remaining_nxt = '0;
        pkt_rem_nxt   = '0;
        pkt_rep_nxt   = 1'b0;
        byte_idx_nxt  = '0;
        partial_nxt   = '0;
      end
      res.image_width  = width_nxt;
      res.image_height = height_nxt;

      case (ph_eff)
        PH_HEADER: begin
          case (hdr_pos_nxt)
            HDR_ID_LEN: id_skip_nxt = b;
            HDR_TYPE:   rle_nxt = (b == TYPE_RLE);
            HDR_W_LO:   width_nxt = {7'd0, b};
            HDR_W_HI:   width_nxt = sat_side({b, width_nxt[7:0]});
            HDR_H_LO:   height_nxt = {7'd0, b};
            HDR_H_HI:   height_nxt = sat_side({b, height_nxt[7:0]});
            HDR_DEPTH: begin
              if (b == {2'b00, PIX_24} || b == {2'b00, PIX_32} ||
                  (b == {2'b00, PIX_16} && !rle_nxt)) begin
                depth_nxt = b[5:0];
              end else begin
                depth_nxt = '0;
              end
            end
            HDR_LAST: begin
              remaining_nxt = total_r;
              if (depth_nxt == '0) begin
                res_valid      = 1'b1;
                res.error_code = 1'b1;
              end
            end
            default: ;
          endcase
          if (hdr_pos_nxt != HDR_LAST) begin
            hdr_pos_nxt = hdr_pos_nxt + 5'd1;
          end
        end

        PH_PIXELS: begin
          if (id_skip_r != '0) begin
            id_skip_nxt = id_skip_r - 8'd1;
          end else if (rle_r && pkt_rem_r == '0) begin
            // packet header: both kinds carry count-1 in the low seven bits
            pkt_rep_nxt = b[7];
            pkt_rem_nxt = (remaining_r < {22'd0, pk}) ? remaining_r[7:0] : pk;
          end else if ({1'b0, byte_idx_r} + 3'd1 < depth_r[5:3]) begin
            case (byte_idx_r)
              2'd0:    partial_nxt[7:0]   = b;
              2'd1:    partial_nxt[15:8]  = b;
              2'd2:    partial_nxt[23:16] = b;
              default: ;
            endcase
            byte_idx_nxt = byte_idx_r + 2'd1;
          end else begin
            if (depth_r == PIX_16) begin
              res.chan0         = {v16[14:10], 3'b000};
              res.chan1         = {v16[9:5], 3'b000};
              res.chan2         = {v16[4:0], 3'b000};
              res.channel_count = CH_RGB;
            end else if (depth_r == PIX_24) begin
              res.chan0         = partial_r[7:0];
              res.chan1         = partial_r[15:8];
              res.chan2         = b;
              res.channel_count = CH_RGB;
            end else begin
              res.chan0         = partial_r[7:0];
              res.chan1         = partial_r[15:8];
              res.chan2         = partial_r[23:16];
              res.chan3         = b;
              res.channel_count = CH_RGBA;
            end
            byte_idx_nxt = '0;
            partial_nxt  = '0;
            if (rle_r && pkt_rep_r) begin
              n           = pkt_rem_r;
              pkt_rem_nxt = '0;
            end else if (rle_r && pkt_rem_r != '0) begin
              pkt_rem_nxt = pkt_rem_r - 8'd1;
            end
            remaining_nxt    = remaining_r - {22'd0, n};
            pix_last         = (remaining_nxt == '0);
            res_valid        = 1'b1;
            res.repeat_count = n;
            res.last_pixel   = pix_last;
          end
        end

        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      hdr_pos_r   <= '0;
      id_skip_r   <= '0;
      rle_r       <= 1'b0;
      width_r     <= '0;
      height_r    <= '0;
      depth_r     <= '0;
      total_r     <= '0;
      remaining_r <= '0;
      pkt_rem_r   <= '0;
      pkt_rep_r   <= 1'b0;
      byte_idx_r  <= '0;
      partial_r   <= '0;
    end else begin
      phase_r     <= phase_nxt;
      hdr_pos_r   <= hdr_pos_nxt;
      id_skip_r   <= id_skip_nxt;
      rle_r       <= rle_nxt;
      width_r     <= width_nxt;
      height_r    <= height_nxt;
      depth_r     <= depth_nxt;
      // image size settles before the last header byte is parsed
      total_r     <= {15'd0, width_r} * {15'd0, height_r};
      remaining_r <= remaining_nxt;
      pkt_rem_r   <= pkt_rem_nxt;
      pkt_rep_r   <= pkt_rep_nxt;
      byte_idx_r  <= byte_idx_nxt;
      partial_r   <= partial_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_remaining_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_PIXELS |-> remaining_r != '0 && remaining_r <= total_r)
    else $error("pixels left out of range while decoding");

  a_packet_within_image: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_PIXELS && rle_r |-> {22'd0, pkt_rem_r} <= remaining_r)
    else $error("run packet extends past the image");

  a_byte_index_bound: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_PIXELS |-> {1'b0, byte_idx_r} < depth_r[5:3])
    else $error("pixel byte index beyond pixel size");

  a_last_ends_image: assert property (@(posedge clk) disable iff (!rst_n)
    advance && res_valid && res.last_pixel |=> phase_r == PH_DONE)
    else $error("decoding continued after the last pixel");
`endif

endmodule

>>> design/tga_out_reg.sv
// TGA decoder result register: holds one result beat until the receiver takes it.
// Depends on tga_pkg.
`timescale 1ns / 1ps

module tga_out_reg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  tga_pkg::tga_out_t res,
  output logic              can_load,
  output logic              out_valid,
  input  logic              out_ready,
  output tga_pkg::tga_out_t out_data
);
  import tga_pkg::*;

  logic     vld_r;
  tga_out_t data_r;

  assign can_load = !vld_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (can_load) begin
      vld_r <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (can_load && load) begin
      data_r <= res;
    end
  end

  assign out_valid = vld_r;
  assign out_data  = data_r;

endmodule

>>> design/targa_image_stream_decoder.sv
// TGA image stream decoder top level: input register, parser, result register.
// Depends on tga_pkg, tga_in_reg, tga_parser, tga_out_reg.
`timescale 1ns / 1ps

// Usage:
//   in_data carries one file byte per beat; set file_start on the first byte
//   of each file, which restarts the parser from any point.
//   out_data carries one pixel (or one run of equal pixels, see repeat_count)
//   per beat, or a single error beat when the pixel depth is unsupported.
//   Header bytes, the id field and run packet headers produce no result.
// Timing: a byte accepted at one edge is parsed at the next edge at which
//   the result register is free; its result is on out_data from then on.
// Throughput: one byte per cycle while the output is not stalled, set by the
//   single parser pass between the input and result registers.
// Reset: rst_n low clears both registers and the parser; bytes are ignored
//   until one arrives with file_start set.
// Stall: while out_ready is low a result is held; the input register still
//   takes one more byte, then in_ready drops until the result is taken.
module targa_image_stream_decoder (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  tga_pkg::tga_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output tga_pkg::tga_out_t out_data
);
  import tga_pkg::*;

  tga_stage_t stage;
  tga_out_t   res;
  logic       res_valid;
  logic       can_load;
  logic       advance;

  assign advance = stage.valid && can_load;

  tga_in_reg u_in_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .take     (advance),
    .stage    (stage)
  );

  tga_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .stage     (stage),
    .advance   (advance),
    .res_valid (res_valid),
    .res       (res)
  );

  tga_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (advance && res_valid),
    .res       (res),
    .can_load  (can_load),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
